@@ sv/edig_pkg.sv @@
// Package: shared widths, codes, state and command types of the DOF index generator.
package edig_pkg;

  localparam int ACTION_W    = 4;
  localparam int COORD_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int DOF_W       = 32;
  localparam int EXACT_W     = 48;
  localparam int COUNT_W     = 4;
  localparam int LOOP_W      = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NODE     = 4'd0,
    ACT_XEDGE    = 4'd1,
    ACT_YEDGE    = 4'd2,
    ACT_FACE     = 4'd3,
    ACT_FACE_G   = 4'd4,
    ACT_VELX     = 4'd5,
    ACT_VELY     = 4'd6,
    ACT_RHO      = 4'd7,
    ACT_THETA    = 4'd8,
    ACT_EXNER    = 4'd9,
    ACT_VELZ     = 4'd10,
    ACT_RHO_G    = 4'd11,
    ACT_THETA_G  = 4'd12,
    ACT_EXNER_G  = 4'd13,
    ACT_VELZ_G   = 4'd14,
    ACT_NONE     = 4'd15
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORDER           = 3'd0,
    REG_ELEMS_PER_SIDE  = 3'd1,
    REG_LEVELS          = 3'd2,
    REG_LOCAL_EDGES     = 3'd3,
    REG_PROC_RANK       = 3'd4,
    REG_FACE_COUNT      = 3'd5,
    REG_PROC_DOF_STRIDE = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } state_t;

  // Setup sequence: one product or sum per cycle, in this order.
  typedef enum logic [3:0] {
    STEP_N,
    STEP_EYP,
    STEP_EXP,
    STEP_PP,
    STEP_EYE,
    STEP_GP,
    STEP_FACE0,
    STEP_FSQ,
    STEP_LLE,
    STEP_VLE,
    STEP_RF,
    STEP_RD,
    STEP_BASE,
    STEP_START
  } step_t;

  typedef struct packed {
    logic  load;
    logic  step_en;
    step_t step;
    logic  advance;
    logic  row_end;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] rows;
    logic [COUNT_W-1:0] cols;
  } status_t;

endpackage

@@ sv/edig_if.sv @@
// Interfaces: request, result and configuration write channels.
interface edig_req_if;
  import edig_pkg::*;
  logic               valid;
  logic               ready;
  logic [ACTION_W-1:0] action;
  logic [COORD_W-1:0]  elem_x;
  logic [COORD_W-1:0]  elem_y;
  logic [COORD_W-1:0]  level;
  modport source (output valid, action, elem_x, elem_y, level, input ready);
  modport sink   (input valid, action, elem_x, elem_y, level, output ready);
endinterface

interface edig_res_if;
  import edig_pkg::*;
  logic             valid;
  logic             ready;
  logic [DOF_W-1:0] dof_index;
  logic             overflow;
  logic             last;
  modport source (output valid, dof_index, overflow, last, input ready);
  modport sink   (input valid, dof_index, overflow, last, output ready);
endinterface

interface edig_cfg_if;
  import edig_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/edig_ctrl.sv @@
// Controller: request sequencing, setup steps and row/column emission counters.
module edig_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  input  edig_pkg::status_t status,
  output edig_pkg::cmd_t    cmd
);
  import edig_pkg::*;

  state_t             state, state_next;
  step_t              step, step_next;
  logic [LOOP_W-1:0]  row_count, row_count_next;
  logic [LOOP_W-1:0]  col_count, col_count_next;
  logic               col_end;
  logic               last;
  logic               empty;

  assign col_end = ({1'b0, col_count} == status.cols - COUNT_W'(1));
  assign last    = col_end && ({1'b0, row_count} == status.rows - COUNT_W'(1));
  assign empty   = (status.rows == '0) || (status.cols == '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        if (step == STEP_START) state_next = empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    out_valid   = 1'b0;
    cmd.load    = 1'b0;
    cmd.step_en = 1'b0;
    cmd.step    = step;
    cmd.advance = 1'b0;
    cmd.row_end = col_end;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_SETUP: begin
        cmd.step_en = 1'b1;
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !last;
      end
      default: ;
    endcase
  end

  assign out_last = last;

  always_comb begin
    step_next      = step;
    row_count_next = row_count;
    col_count_next = col_count;
    if (state == ST_SETUP && step != STEP_START) begin
      step_next = step_t'(4'(step) + 4'd1);
    end else if (state != ST_SETUP) begin
      step_next = STEP_N;
    end
    if (cmd.advance) begin
      if (col_end) begin
        col_count_next = '0;
        row_count_next = row_count + LOOP_W'(1);
      end else begin
        col_count_next = col_count + LOOP_W'(1);
      end
    end else if (state != ST_EMIT) begin
      // clear between requests
      row_count_next = '0;
      col_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_N;
      row_count <= '0;
      col_count <= '0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

endmodule

@@ sv/edig_datapath.sv @@
// Datapath: configuration registers, request hold, shared multiplier and index accumulator.
module edig_datapath #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [edig_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [edig_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [edig_pkg::ACTION_W-1:0]    req_action,
  input  logic [edig_pkg::COORD_W-1:0]     req_elem_x,
  input  logic [edig_pkg::COORD_W-1:0]     req_elem_y,
  input  logic [edig_pkg::COORD_W-1:0]     req_level,
  input  edig_pkg::cmd_t                   cmd,
  output edig_pkg::status_t                status,
  output logic [edig_pkg::DOF_W-1:0]       dof_index,
  output logic                             overflow
);
  import edig_pkg::*;

  localparam int MUL_A_W = 11;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // configuration
  logic [2:0]  order;
  logic [7:0]  elems_per_side;
  logic [7:0]  levels;
  logic [23:0] local_edges;
  logic [9:0]  proc_rank;
  logic [23:0] face_count;
  logic [31:0] proc_dof_stride;

  // held request
  action_t             act;
  logic [COORD_W-1:0]  ex, ey, lev;

  // setup results
  logic [10:0] n, eyp, exp_r;
  logic [5:0]  pp;
  logic [15:0] eye;
  logic [21:0] gp, face0;
  logic [31:0] fsq, lle, vle;
  logic [33:0] rf;
  logic [41:0] rd;
  logic [EXACT_W-1:0] base_index;
  logic [EXACT_W-1:0] cur, row_start;

  logic               grid, isx, isy, var_kind, global_var, face_kind;
  logic [1:0]         comp;
  logic [9:0]         fstride;
  logic [10:0]        gstride;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [22:0]        v0;
  logic [23:0]        scaled;
  logic [EXACT_W-1:0] step_col, step_row, start, row_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      order           <= 3'd3;
      elems_per_side  <= 8'd4;
      levels          <= 8'd8;
      local_edges     <= 24'd1;
      proc_rank       <= '0;
      face_count      <= '0;
      proc_dof_stride <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ORDER:           order           <= cfg_data[2:0];
        REG_ELEMS_PER_SIDE:  elems_per_side  <= cfg_data[7:0];
        REG_LEVELS:          levels          <= cfg_data[7:0];
        REG_LOCAL_EDGES:     local_edges     <= cfg_data[23:0];
        REG_PROC_RANK:       proc_rank       <= cfg_data[9:0];
        REG_FACE_COUNT:      face_count      <= cfg_data[23:0];
        REG_PROC_DOF_STRIDE: proc_dof_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action_t'(req_action);
      ex  <= req_elem_x;
      ey  <= req_elem_y;
      lev <= req_level;
    end
  end

  // kind decode
  always_comb begin
    grid       = act inside {ACT_NODE, ACT_XEDGE, ACT_YEDGE, ACT_VELX, ACT_VELY};
    isx        = act inside {ACT_XEDGE, ACT_VELX};
    isy        = act inside {ACT_YEDGE, ACT_VELY};
    var_kind   = act inside {[ACT_RHO:ACT_VELZ_G]};
    global_var = act inside {[ACT_RHO_G:ACT_VELZ_G]};
    face_kind  = act inside {ACT_FACE, ACT_FACE_G} || var_kind;
    comp       = 2'(4'(act) - 4'(ACT_RHO));
    // level stride saturates at zero when there are no levels
    if (!var_kind)         fstride = 10'd1;
    else if (levels == '0) fstride = '0;
    else                   fstride = 10'({levels, 2'b00}) - 10'd1;
    gstride = isy ? n : n + 11'd1;
  end

  always_comb begin
    status.rows = '0;
    status.cols = '0;
    if (grid) begin
      status.rows = isx ? COUNT_W'(order) : COUNT_W'(order) + COUNT_W'(1);
      status.cols = isy ? COUNT_W'(order) : COUNT_W'(order) + COUNT_W'(1);
    end else if (face_kind) begin
      status.rows = COUNT_W'(order);
      status.cols = COUNT_W'(order);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      STEP_N:     begin mul_a = MUL_A_W'(order);      mul_b = MUL_B_W'(elems_per_side); end
      STEP_EYP:   begin mul_a = MUL_A_W'(order);      mul_b = MUL_B_W'(ey); end
      STEP_EXP:   begin mul_a = MUL_A_W'(order);      mul_b = MUL_B_W'(ex); end
      STEP_PP:    begin mul_a = MUL_A_W'(order);      mul_b = MUL_B_W'(order); end
      STEP_EYE:   begin mul_a = MUL_A_W'(ey);         mul_b = MUL_B_W'(elems_per_side); end
      STEP_GP:    begin mul_a = eyp;                  mul_b = MUL_B_W'(gstride); end
      STEP_FACE0: begin
        mul_a = MUL_A_W'(pp);
        mul_b = MUL_B_W'(17'(eye) + 17'(ex));
      end
      STEP_FSQ:   begin mul_a = MUL_A_W'(fstride);    mul_b = MUL_B_W'(face0); end
      STEP_LLE:   begin mul_a = MUL_A_W'(lev);        mul_b = MUL_B_W'(local_edges); end
      STEP_VLE:   begin mul_a = MUL_A_W'(levels);     mul_b = MUL_B_W'(local_edges); end
      STEP_RF:    begin mul_a = MUL_A_W'(proc_rank);  mul_b = MUL_B_W'(face_count); end
      STEP_RD:    begin mul_a = MUL_A_W'(proc_rank);  mul_b = proc_dof_stride; end
      default: ;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // grid kinds: scaled index steps by one or two per column, by the scaled stride per row
  always_comb begin
    v0     = 23'(gp) + 23'(exp_r);
    scaled = (act == ACT_NODE) ? 24'(v0) : {v0, isy};
    start  = base_index + (grid ? EXACT_W'(scaled) : EXACT_W'(fsq));
    if (grid) begin
      step_col = (act == ACT_NODE) ? EXACT_W'(1) : EXACT_W'(2);
      step_row = (act == ACT_NODE) ? EXACT_W'(gstride) : EXACT_W'({gstride, 1'b0});
    end else begin
      step_col = EXACT_W'(fstride);
      step_row = EXACT_W'(fstride);
    end
    row_next = row_start + step_row;
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      case (cmd.step)
        STEP_N:     n     <= prod[10:0];
        STEP_EYP:   eyp   <= prod[10:0];
        STEP_EXP:   exp_r <= prod[10:0];
        STEP_PP:    pp    <= prod[5:0];
        STEP_EYE:   eye   <= prod[15:0];
        STEP_GP:    gp    <= prod[21:0];
        STEP_FACE0: face0 <= prod[21:0];
        STEP_FSQ:   fsq   <= prod[31:0];
        STEP_LLE:   lle   <= prod[31:0];
        STEP_VLE:   vle   <= prod[31:0];
        STEP_RF:    rf    <= prod[33:0];
        STEP_RD:    rd    <= prod[41:0];
        STEP_BASE: begin
          if (grid)
            base_index <= (act == ACT_VELX || act == ACT_VELY) ? EXACT_W'(lle) : '0;
          else if (act == ACT_FACE_G)
            base_index <= EXACT_W'(rf);
          else if (var_kind)
            base_index <= EXACT_W'(vle) + EXACT_W'({lev, comp})
                          + (global_var ? EXACT_W'(rd) : '0);
          else
            base_index <= '0;
        end
        STEP_START: begin
          cur       <= start;
          row_start <= start;
        end
        default: ;
      endcase
    end else if (cmd.advance) begin
      if (cmd.row_end && grid) begin
        row_start <= row_next;
        cur       <= row_next;
      end else begin
        cur <= cur + step_col;
      end
    end
  end

  generate
    if (INDEX_WIDTH >= DOF_W) begin : g_dof_full
      assign dof_index = cur[DOF_W-1:0];
    end else begin : g_dof_narrow
      assign dof_index = DOF_W'(cur[INDEX_WIDTH-1:0]);
    end
    if (INDEX_WIDTH >= EXACT_W) begin : g_ovf_none
      assign overflow = 1'b0;
    end else begin : g_ovf
      assign overflow = |cur[EXACT_W-1:INDEX_WIDTH];
    end
  endgenerate

endmodule

@@ sv/element_dof_index_generator_top.sv @@
// Top level: element degree-of-freedom index generator.
//
// Usage: one request item on req (action, elem_x, elem_y, level) produces the
// element's DOF indices on res, in row-major order, with last set on the final
// one. res.overflow flags an exact index that did not fit INDEX_WIDTH bits.
// Kind 15, and every kind but node at order zero, produce no results.
// cfg writes a register (index 0 order .. 6 proc_dof_stride) when cfg.valid is high;
// write only while no request is in flight. cfg.ready is always high.
// Sequence: req is taken in the idle state, then the setup steps run the base
// products through one shared 11x32 multiplier, one product per cycle, then
// one index per cycle leaves while res.ready is high: up to (order+1)^2 = 64
// results per request. The next request is taken only once the final result
// has been taken. A stall on res holds the current index; nothing is lost or
// repeated. Reset (rst, synchronous) returns the sequencer to idle and loads
// the register defaults: order 3, elems_per_side 4, levels 8, local_edges 1.
module element_dof_index_generator_top #(
  parameter int INDEX_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  edig_req_if.sink   req,
  edig_res_if.source res,
  edig_cfg_if.sink   cfg
);
  import edig_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  edig_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_last  (res.last),
    .status    (status),
    .cmd       (cmd)
  );

  edig_datapath #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .req_action (req.action),
    .req_elem_x (req.elem_x),
    .req_elem_y (req.elem_y),
    .req_level  (req.level),
    .cmd        (cmd),
    .status     (status),
    .dof_index  (res.dof_index),
    .overflow   (res.overflow)
  );

endmodule
